// ===== rtl/cglr_pkg.sv =====
// Shared types and constants of the character grid line rasterizer.
`timescale 1ns / 1ps

package cglr_pkg;

    localparam int VEC_W    = 8;
    localparam int ORG_W    = 11;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 11;
    localparam int ADDR_W   = 20;
    localparam int GRID_W   = 11;
    localparam int IDX_W    = 2;
    localparam int RES_CAP  = 64;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_ROWS  = 2'd1;

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [ORG_W-1:0]  t_origin;
    typedef logic signed [COL_W-1:0]  t_column;
    typedef logic signed [ROW_W-1:0]  t_row;
    typedef logic        [ADDR_W-1:0] t_addr;
    typedef logic        [GRID_W-1:0] t_grid;
    typedef logic        [IDX_W-1:0]  t_reg_idx;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/cglr_in_if.sv =====
// Vector input channel.
`timescale 1ns / 1ps

interface cglr_in_if import cglr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_vec    vec_x;
    t_vec    vec_y;
    t_origin origin_x;
    t_origin origin_y;

    modport source (output valid, vec_x, vec_y, origin_x, origin_y, input ready);
    modport sink   (input valid, vec_x, vec_y, origin_x, origin_y, output ready);
endinterface

// ===== rtl/cglr_out_if.sv =====
// Plotted cell output channel.
`timescale 1ns / 1ps

interface cglr_out_if import cglr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_column column;
    t_row    row;
    t_addr   cell_address;
    logic    off_grid;
    logic    last_point;

    modport source (output valid, column, row, cell_address, off_grid, last_point,
                    input ready);
    modport sink   (input valid, column, row, cell_address, off_grid, last_point,
                    output ready);
endinterface

// ===== rtl/cglr_ctrl.sv =====
// Sequencer of the line rasterizer: accept, set up, step.
`timescale 1ns / 1ps

module cglr_ctrl import cglr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/cglr_datapath.sv =====
// Line stepping datapath: setup, rounded minor tracking, grid address, output register.
`timescale 1ns / 1ps

module cglr_datapath import cglr_pkg::*; #(
    parameter int MAX_SPAN     = 64,
    parameter int MAX_GRID_DIM = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    output t_dp_sts  o_sts,
    input  logic     i_cfg_wr_en,
    input  t_reg_idx i_cfg_index,
    input  t_grid    i_cfg_wdata,
    input  t_vec     i_vec_x,
    input  t_vec     i_vec_y,
    input  t_origin  i_origin_x,
    input  t_origin  i_origin_y,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_column  o_column,
    output t_row     o_row,
    output t_addr    o_cell_address,
    output logic     o_off_grid,
    output logic     o_last_point
);

    localparam int SPAN_CAP = (MAX_SPAN < RES_CAP) ? MAX_SPAN : RES_CAP;
    localparam logic signed [VEC_W-1:0] CAP_POS = VEC_W'(SPAN_CAP);
    localparam logic signed [VEC_W-1:0] CAP_NEG = VEC_W'(-SPAN_CAP);
    localparam int GRID_MAX = (1 << GRID_W) - 1;
    localparam logic [GRID_W-1:0] GRID_CAP =
        (MAX_GRID_DIM > GRID_MAX) ? GRID_W'(GRID_MAX) : GRID_W'(MAX_GRID_DIM);

    // grid registers
    t_grid r_grid_width;
    t_grid r_grid_rows;
    t_grid w_cfg_val;

    assign w_cfg_val = (i_cfg_wdata > GRID_CAP) ? GRID_CAP : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_W'(80);
            r_grid_rows  <= GRID_W'(24);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRID_WIDTH: r_grid_width <= w_cfg_val;
                REG_GRID_ROWS:  r_grid_rows  <= w_cfg_val;
                default: ;
            endcase
        end
    end

    // setup of one vector
    t_vec        w_vx;
    t_vec        w_vy;
    logic [6:0]  w_ax;
    logic [6:0]  w_ay;
    logic        w_along_x;
    t_vec        w_maj;
    t_vec        w_min;
    logic [6:0]  w_den;
    t_vec        w_inc;

    always_comb begin
        w_vx = (i_vec_x > CAP_POS) ? CAP_POS : ((i_vec_x < CAP_NEG) ? CAP_NEG : i_vec_x);
        w_vy = (i_vec_y > CAP_POS) ? CAP_POS : ((i_vec_y < CAP_NEG) ? CAP_NEG : i_vec_y);
        w_ax = w_vx[VEC_W-1] ? 7'(-w_vx) : w_vx[6:0];
        w_ay = w_vy[VEC_W-1] ? 7'(-w_vy) : w_vy[6:0];
        w_along_x = (w_ax >= w_ay);
        w_maj = w_along_x ? w_vx : w_vy;
        w_min = w_along_x ? w_vy : w_vx;
        w_den = w_along_x ? w_ax : w_ay;
        w_inc = w_maj[VEC_W-1] ? -w_min : w_min;
    end

    logic        r_along_x;
    logic        r_d_neg;
    logic        r_zero;
    logic [6:0]  r_den;
    t_vec        r_inc;
    t_origin     r_o_minor;
    t_origin     r_o_major;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_along_x <= w_along_x;
            r_d_neg   <= w_maj[VEC_W-1];
            r_zero    <= (w_den == 7'd0);
            r_den     <= w_den;
            r_inc     <= w_inc;
            r_o_minor <= w_along_x ? i_origin_y : i_origin_x;
            r_o_major <= w_along_x ? i_origin_x : i_origin_y;
        end
    end

    // rounded minor coordinate: X = 2N+den = q*2den + rem, 0 <= rem < 2den
    logic [7:0]          w_den2;
    t_vec                w_r0;
    t_column             w_base;
    logic signed [9:0]   w_rem_init;
    logic signed [9:0]   w_rem_step;
    logic signed [9:0]   w_rem_sel;
    t_column             w_q_sel;
    logic signed [9:0]   w_den2_s;
    t_column             n_q;
    logic [7:0]          n_rem;

    t_column     r_q;
    logic [7:0]  r_rem;
    t_column     r_major;
    logic [6:0]  r_count;

    always_comb begin
        w_den2     = {r_den, 1'b0};
        w_den2_s   = signed'({2'b00, w_den2});
        w_r0       = r_d_neg ? r_inc : '0;
        w_base     = COL_W'(r_o_minor) - COL_W'(w_r0);
        w_rem_init = (10'(w_r0) <<< 1) + signed'({3'b000, r_den});
        w_rem_step = signed'({2'b00, r_rem}) + (10'(r_inc) <<< 1);
        w_rem_sel  = i_cmd.init ? w_rem_init : w_rem_step;
        w_q_sel    = i_cmd.init ? w_base : r_q;
        if (w_rem_sel < 0) begin
            n_rem = 8'(w_rem_sel + w_den2_s);
            n_q   = w_q_sel - COL_W'(1);
        end else if (w_rem_sel >= w_den2_s) begin
            n_rem = 8'(w_rem_sel - w_den2_s);
            n_q   = w_q_sel + COL_W'(1);
        end else begin
            n_rem = 8'(w_rem_sel);
            n_q   = w_q_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_q     <= n_q;
            r_rem   <= n_rem;
            r_major <= COL_W'(r_o_major) +
                       (r_d_neg ? (COL_W'(1) - COL_W'(r_den)) : COL_W'(0));
            r_count <= r_zero ? 7'd1 : r_den;
        end else if (i_cmd.step) begin
            r_q     <= n_q;
            r_rem   <= n_rem;
            r_major <= r_major + COL_W'(1);
            r_count <= r_count - 7'd1;
        end
    end

    // point of the current step
    logic                  w_nonneg;
    t_column               w_minor;
    t_column               w_col;
    t_column               w_yr;
    t_column               w_yr_adj;
    t_row                  w_row;
    logic                  w_off;
    logic [2*GRID_W-1:0]   w_prod;
    logic [2*GRID_W-1:0]   w_sum;

    always_comb begin
        w_nonneg = (r_q > 0) || ((r_q == 0) && (r_rem >= {1'b0, r_den}));
        if (r_zero) begin
            w_minor = COL_W'(r_o_minor);
        end else if (w_nonneg || (r_rem != 8'd0)) begin
            w_minor = r_q;
        end else begin
            w_minor = r_q - COL_W'(1);
        end
        w_col    = r_along_x ? r_major : w_minor;
        w_yr     = r_along_x ? w_minor : r_major;
        w_yr_adj = w_yr + COL_W'(w_yr[COL_W-1]);
        w_row    = w_yr_adj[COL_W-1:1];
        w_off    = w_col[COL_W-1] || w_row[ROW_W-1] ||
                   (w_col[GRID_W-1:0] >= r_grid_width) ||
                   ({1'b0, w_row[ROW_W-2:0]} >= r_grid_rows);
        w_prod   = r_grid_width * {1'b0, w_row[ROW_W-2:0]};
        w_sum    = w_prod + (2*GRID_W)'(w_col[GRID_W-1:0]);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_column       <= w_col;
            o_row          <= w_row;
            o_cell_address <= w_off ? '0 : w_sum[ADDR_W-1:0];
            o_off_grid     <= w_off;
            o_last_point   <= (r_count == 7'd1);
        end
    end

    assign o_sts.last_step = (r_count == 7'd1);
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

endmodule

// ===== rtl/char_grid_line_rasterizer.sv =====
// Top level of the character grid line rasterizer.
//
//  channel   dir  handshake          beat
//  i_vec     in   valid/ready        vec_x, vec_y, origin_x, origin_y
//  o_pt      out  valid/ready        column, row, cell_address, off_grid, last_point
//  i_cfg_*   in   write enable only  grid_width (index 0), grid_rows (index 1)
//
//  A vector gives n points, n = max(|major component|, 1) <= 64: a setup step after the input
//  beat, then one output beat per cycle from the stepping datapath while o_pt is not stalled.
//  Reset is synchronous, active low; it idles the sequencer and restores grid 80 x 24.
//  A stall on o_pt holds the current step; a new vector is taken once the last
//  point is in the output register.
`timescale 1ns / 1ps

module char_grid_line_rasterizer import cglr_pkg::*; #(
    parameter int MAX_SPAN     = 64,
    parameter int MAX_GRID_DIM = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cglr_in_if.sink        i_vec,
    cglr_out_if.source     o_pt,
    input  logic           i_cfg_wr_en,
    input  t_reg_idx       i_cfg_index,
    input  t_grid          i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cglr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vec.valid),
        .o_in_ready (i_vec.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cglr_datapath #(
        .MAX_SPAN     (MAX_SPAN),
        .MAX_GRID_DIM (MAX_GRID_DIM)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_vec_x        (i_vec.vec_x),
        .i_vec_y        (i_vec.vec_y),
        .i_origin_x     (i_vec.origin_x),
        .i_origin_y     (i_vec.origin_y),
        .i_out_ready    (o_pt.ready),
        .o_out_valid    (o_pt.valid),
        .o_column       (o_pt.column),
        .o_row          (o_pt.row),
        .o_cell_address (o_pt.cell_address),
        .o_off_grid     (o_pt.off_grid),
        .o_last_point   (o_pt.last_point)
    );

endmodule
